// File: hdl/slte_pkg.sv
package slte_pkg;

    localparam logic [2:0] FUNC_SERIAL      = 3'd0;
    localparam logic [2:0] FUNC_START_RECV  = 3'd1;
    localparam logic [2:0] FUNC_START_SEND  = 3'd2;
    localparam logic [2:0] FUNC_WRITE_BUF   = 3'd3;
    localparam logic [2:0] FUNC_ENTER_SYNC  = 3'd4;
    localparam logic [2:0] FUNC_READ_BUF    = 3'd5;

    typedef enum logic [1:0] {
        LINK_OFF      = 2'd0,
        LINK_RECEIVE  = 2'd1,
        LINK_TRANSMIT = 2'd2,
        LINK_SYNC     = 2'd3
    } mode_t;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_BUSY      = 3'd1;
    localparam logic [2:0] ST_WAIT_SYNC = 3'd2;
    localparam logic [2:0] ST_COMPLETE  = 3'd3;
    localparam logic [2:0] ST_FAILED    = 3'd4;
    localparam logic [2:0] ST_SYNC_DONE = 3'd5;

    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_BODY    = 3'd1;
    localparam logic [2:0] PH_ESCAPE  = 3'd2;
    localparam logic [2:0] PH_CHECK   = 3'd3;
    localparam logic [2:0] PH_SYNC    = 3'd4;
    localparam logic [2:0] PH_SYNCED  = 3'd5;

    localparam logic [7:0] BYTE_FRAME_START = 8'hFD;
    localparam logic [7:0] BYTE_ESCAPE      = 8'hFF;
    localparam logic [7:0] BYTE_FRAME_END   = 8'hFE;
    localparam logic [7:0] CRC_POLY         = 8'h31;
    localparam logic [7:0] CRC_INIT         = 8'hFF;
    localparam logic [7:0] BYTE_DATA_TAG    = 8'h80;
    localparam logic [7:0] BYTE_DATA_MASK   = 8'h1F;
    localparam logic [7:0] BYTE_TRAILER     = 8'hC0;
    localparam logic [7:0] BYTE_TRAILER_ACK = 8'hC1;
    localparam logic [7:0] BYTE_SYNC        = 8'hE0;
    localparam logic [7:0] BYTE_SYNC_ACK    = 8'hE1;

    typedef struct packed {
        logic [9:0] send_length;
        logic [8:0] entry_index;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [9:0] byte_count;
        logic       progress_notify;
        logic       status_notify;
        logic [2:0] link_status;
        logic       tx_restart;
        logic [7:0] tx_byte;
    } result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/slte_buffer.sv
module slte_buffer #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] q_reg;
    logic [7:0] byp_reg;
    logic       hit_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            q_reg   <= mem[raddr];
            byp_reg <= wdata;
            hit_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = hit_reg ? byp_reg : q_reg;

endmodule

// File: hdl/slte_engine.sv
module slte_engine #(
    parameter int BUFFER_DEPTH = 512,
    parameter int ADDR_W       = 9,
    parameter int CNT_W        = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 exec_en,
    input  logic [2:0]           func,
    input  slte_pkg::item_t      item,
    input  logic [7:0]           mem_rdata,
    output logic                 mem_we,
    output logic [ADDR_W-1:0]    mem_waddr,
    output logic [7:0]           mem_wdata,
    output logic [CNT_W-1:0]     offset_ahead,
    output slte_pkg::result_t    result
);

    localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(BUFFER_DEPTH);

    slte_pkg::mode_t  mode_reg, mode_next;
    logic [2:0]       phase_reg, phase_next, phase_eff;
    logic [7:0]       pending_reg, pending_next;
    logic [2:0]       status_reg, status_next;
    logic [CNT_W-1:0] length_reg, length_next;
    logic [CNT_W-1:0] offset_reg, offset_next;
    logic [7:0]       crc_reg, crc_next;
    logic             restart, snote, pnote, do_store, idx_ok;
    logic [7:0]       rd;
    logic [7:0]       d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= slte_pkg::LINK_OFF;
            phase_reg   <= slte_pkg::PH_START;
            pending_reg <= '0;
            status_reg  <= slte_pkg::ST_IDLE;
            length_reg  <= '0;
            offset_reg  <= '0;
            crc_reg     <= slte_pkg::CRC_INIT;
        end else if (exec_en) begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            status_reg  <= status_next;
            length_reg  <= length_next;
            offset_reg  <= offset_next;
            crc_reg     <= crc_next;
        end
    end

    always_comb begin
        d            = item.data_byte;
        idx_ok       = CMP_W'(item.entry_index) < DEPTH_W;
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        phase_eff    = phase_reg;
        pending_next = pending_reg;
        status_next  = status_reg;
        length_next  = length_reg;
        offset_next  = offset_reg;
        crc_next     = crc_reg;
        restart      = 1'b0;
        snote        = 1'b0;
        pnote        = 1'b0;
        do_store     = 1'b0;
        rd           = '0;
        mem_we       = 1'b0;
        mem_waddr    = offset_reg[ADDR_W-1:0];
        mem_wdata    = d;

        case (func)
            slte_pkg::FUNC_SERIAL: begin
                restart = 1'b1;
                case (mode_reg)
                    slte_pkg::LINK_RECEIVE: begin
                        case (phase_reg)
                            slte_pkg::PH_START: begin
                                if (d == slte_pkg::BYTE_FRAME_START) begin
                                    phase_next  = slte_pkg::PH_BODY;
                                    status_next = slte_pkg::ST_BUSY;
                                    snote       = 1'b1;
                                end
                            end
                            slte_pkg::PH_BODY: begin
                                if (d == slte_pkg::BYTE_ESCAPE) begin
                                    phase_next = slte_pkg::PH_ESCAPE;
                                end else if (d == slte_pkg::BYTE_FRAME_END) begin
                                    phase_next = slte_pkg::PH_CHECK;
                                end else begin
                                    do_store = 1'b1;
                                end
                            end
                            slte_pkg::PH_ESCAPE: begin
                                do_store   = 1'b1;
                                phase_next = slte_pkg::PH_BODY;
                            end
                            slte_pkg::PH_CHECK: begin
                                status_next = (d == crc_reg) ? slte_pkg::ST_COMPLETE
                                                             : slte_pkg::ST_FAILED;
                                snote       = 1'b1;
                                restart     = 1'b0;
                            end
                            default: begin
                            end
                        endcase
                        if (do_store && offset_reg < DEPTH_C) begin
                            mem_we      = 1'b1;
                            offset_next = offset_reg + 1'b1;
                            crc_next    = slte_pkg::crc8_update(crc_reg, d);
                            pnote       = 1'b1;
                        end
                    end
                    slte_pkg::LINK_TRANSMIT: begin
                        if (phase_reg == slte_pkg::PH_START) begin
                            phase_eff   = slte_pkg::PH_BODY;
                            phase_next  = slte_pkg::PH_BODY;
                            status_next = slte_pkg::ST_BUSY;
                            snote       = 1'b1;
                        end
                        if (phase_eff == slte_pkg::PH_BODY) begin
                            if (pending_reg == d) begin
                                if (offset_reg < length_reg && offset_reg < DEPTH_C) begin
                                    pending_next = slte_pkg::BYTE_DATA_TAG
                                                 | (mem_rdata & slte_pkg::BYTE_DATA_MASK);
                                    offset_next  = offset_reg + 1'b1;
                                    pnote        = 1'b1;
                                end else begin
                                    pending_next = slte_pkg::BYTE_TRAILER;
                                    phase_next   = slte_pkg::PH_ESCAPE;
                                end
                            end
                        end else if (phase_eff == slte_pkg::PH_ESCAPE) begin
                            if (d == slte_pkg::BYTE_TRAILER_ACK) begin
                                phase_next  = slte_pkg::PH_CHECK;
                                status_next = slte_pkg::ST_WAIT_SYNC;
                                snote       = 1'b1;
                            end
                        end else if (phase_eff == slte_pkg::PH_CHECK) begin
                            if (d != slte_pkg::BYTE_TRAILER_ACK) begin
                                status_next = slte_pkg::ST_FAILED;
                            end
                            pnote = 1'b1;
                        end
                    end
                    slte_pkg::LINK_SYNC: begin
                        if (phase_reg == slte_pkg::PH_CHECK) begin
                            pending_next = slte_pkg::BYTE_SYNC;
                            phase_next   = slte_pkg::PH_SYNC;
                        end else if (phase_reg == slte_pkg::PH_SYNC) begin
                            if (d == slte_pkg::BYTE_SYNC_ACK) begin
                                phase_next  = slte_pkg::PH_SYNCED;
                                status_next = slte_pkg::ST_SYNC_DONE;
                                snote       = 1'b1;
                                restart     = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            slte_pkg::FUNC_START_RECV, slte_pkg::FUNC_START_SEND: begin
                mode_next    = (func == slte_pkg::FUNC_START_RECV) ? slte_pkg::LINK_RECEIVE
                                                                   : slte_pkg::LINK_TRANSMIT;
                pending_next = d;
                offset_next  = '0;
                phase_next   = slte_pkg::PH_START;
                status_next  = slte_pkg::ST_IDLE;
                crc_next     = slte_pkg::CRC_INIT;
                if (func == slte_pkg::FUNC_START_SEND && item.send_length != '0) begin
                    if (CMP_W'(item.send_length) > DEPTH_W) begin
                        length_next = DEPTH_C;
                    end else begin
                        length_next = CNT_W'(item.send_length);
                    end
                end
                restart = 1'b1;
            end
            slte_pkg::FUNC_WRITE_BUF: begin
                mem_waddr = ADDR_W'(item.entry_index);
                mem_we    = idx_ok;
            end
            slte_pkg::FUNC_ENTER_SYNC: begin
                mode_next = slte_pkg::LINK_SYNC;
            end
            slte_pkg::FUNC_READ_BUF: begin
                if (idx_ok) begin
                    rd = mem_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    assign offset_ahead = exec_en ? offset_next : offset_reg;

    always_comb begin
        result.tx_byte         = pending_next;
        result.tx_restart      = restart;
        result.link_status     = status_next;
        result.status_notify   = snote;
        result.progress_notify = pnote;
        result.byte_count      = 10'(offset_next);
        result.read_byte       = rd;
    end

endmodule

// File: hdl/serial_link_transfer_engine.sv
// Serial link transfer engine.
// Input stream (s_): one transaction per event. s_tuser carries func; s_tdata carries,
// from bit 0 up, data_byte[7:0], entry_index[16:8], send_length[26:17], zeros above.
// Output stream (m_): exactly one transaction per input transaction, in order, with
// tx_byte, tx_restart, link_status, status_notify, progress_notify, byte_count and
// read_byte packed into m_tdata.
// An accepted input is held in the input register, then executes into the output
// register driving m_tvalid. The frame buffer is read at acceptance: the read address
// is the next send offset, or entry_index for a buffer read, and the registered read
// data is ready when the item executes. One transaction per cycle unless m_tready stalls.
// Reset (aresetn low, synchronous) returns the engine to no mode, idle status, zero
// offsets and length, CRC 0xFF, and empties both pipeline registers. Buffer contents
// are not cleared and hold no defined value until written.
// When the receiver deasserts m_tready, the result holds on m_tdata, one more input is
// taken only if the input register is empty, and s_tready drops until the stall clears.
module serial_link_transfer_engine #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_byte, entry_index, send_length
    input  logic [2:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // tx_byte, tx_restart, link_status, status_notify,
                                   // progress_notify, byte_count, read_byte
);

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

    logic               s1_valid_reg;
    logic [2:0]         s1_func_reg;
    slte_pkg::item_t    s1_item_reg;
    logic               m_valid_reg;
    slte_pkg::result_t  m_data_reg;
    logic               advance;
    logic               accept;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [7:0]         mem_rdata;
    logic [CNT_W-1:0]   offset_ahead;
    slte_pkg::result_t  result;
    slte_pkg::item_t    in_item;

    assign in_item  = slte_pkg::item_t'(s_tdata[26:0]);
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign mem_raddr = (s_tuser == slte_pkg::FUNC_READ_BUF) ? ADDR_W'(in_item.entry_index)
                                                            : offset_ahead[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_func_reg <= s_tuser;
            s1_item_reg <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    slte_buffer #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_buffer (
        .aclk  (aclk),
        .we    (mem_we && advance),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    slte_engine #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDR_W       (ADDR_W),
        .CNT_W        (CNT_W)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .exec_en      (advance),
        .func         (s1_func_reg),
        .item         (s1_item_reg),
        .mem_rdata    (mem_rdata),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .offset_ahead (offset_ahead),
        .result       (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: verif/tb_serial_link_transfer_engine.sv
module tb_serial_link_transfer_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import slte_pkg::*;

    localparam int          BUF_DEPTH     = 512;
    localparam int          RANDOM_ITEMS  = 1550;
    localparam int          STALL_LIMIT   = 2000;
    localparam logic [2:0]  FUNC_UNUSED_A = 3'd6;
    localparam logic [2:0]  FUNC_UNUSED_B = 3'd7;

    class link_scoreboard;
        mode_t       mode;
        logic [2:0]  ph;
        logic [7:0]  cmd;
        logic [2:0]  status;
        logic [7:0]  store [BUF_DEPTH];
        bit          known [BUF_DEPTH];
        int unsigned flen;
        int unsigned offset;
        logic [7:0]  crc;
        result_t     results_due [$];
        int          errors;
        int          checked;
        int          status_events [8];

        function new();
            mode    = LINK_OFF;
            ph      = PH_START;
            cmd     = '0;
            status  = ST_IDLE;
            flen    = 0;
            offset  = 0;
            crc     = CRC_INIT;
            errors  = 0;
            checked = 0;
            foreach (status_events[i]) status_events[i] = 0;
        endfunction

        function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
            logic [7:0] v;
            v = c ^ b;
            repeat (8) v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
            return v;
        endfunction

        function bit keep_byte(logic [7:0] b);
            if (offset >= BUF_DEPTH) return 1'b0;
            store[offset] = b;
            known[offset] = 1'b1;
            offset++;
            crc = crc_next(crc, b);
            return 1'b1;
        endfunction

        function void note_accepted(logic [2:0] f, item_t it);
            result_t    r;
            logic [7:0] d;
            bit         go;
            bit         sn;
            bit         pn;
            r  = '0;
            d  = it.data_byte;
            go = 1'b0;
            sn = 1'b0;
            pn = 1'b0;
            case (f)
                FUNC_SERIAL: begin
                    go = 1'b1;
                    case (mode)
                        LINK_RECEIVE: begin
                            case (ph)
                                PH_START: begin
                                    if (d == BYTE_FRAME_START) begin
                                        ph     = PH_BODY;
                                        status = ST_BUSY;
                                        sn     = 1'b1;
                                    end
                                end
                                PH_BODY: begin
                                    if (d == BYTE_ESCAPE) begin
                                        ph = PH_ESCAPE;
                                    end else if (d == BYTE_FRAME_END) begin
                                        ph = PH_CHECK;
                                    end else begin
                                        pn = keep_byte(d);
                                    end
                                end
                                PH_ESCAPE: begin
                                    pn = keep_byte(d);
                                    ph = PH_BODY;
                                end
                                PH_CHECK: begin
                                    status = (d == crc) ? ST_COMPLETE : ST_FAILED;
                                    sn     = 1'b1;
                                    go     = 1'b0;
                                end
                                default: ;
                            endcase
                        end
                        LINK_TRANSMIT: begin
                            if (ph == PH_START) begin
                                ph     = PH_BODY;
                                status = ST_BUSY;
                                sn     = 1'b1;
                            end
                            if (ph == PH_BODY) begin
                                if (cmd == d) begin
                                    if (offset < flen && offset < BUF_DEPTH) begin
                                        cmd = BYTE_DATA_TAG | (store[offset] & BYTE_DATA_MASK);
                                        offset++;
                                        pn = 1'b1;
                                    end else begin
                                        cmd = BYTE_TRAILER;
                                        ph  = PH_ESCAPE;
                                    end
                                end
                            end else if (ph == PH_ESCAPE) begin
                                if (d == BYTE_TRAILER_ACK) begin
                                    ph     = PH_CHECK;
                                    status = ST_WAIT_SYNC;
                                    sn     = 1'b1;
                                end
                            end else if (ph == PH_CHECK) begin
                                if (d != BYTE_TRAILER_ACK) status = ST_FAILED;
                                pn = 1'b1;
                            end
                        end
                        LINK_SYNC: begin
                            if (ph == PH_CHECK) begin
                                cmd = BYTE_SYNC;
                                ph  = PH_SYNC;
                            end else if (ph == PH_SYNC && d == BYTE_SYNC_ACK) begin
                                ph     = PH_SYNCED;
                                status = ST_SYNC_DONE;
                                sn     = 1'b1;
                                go     = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                FUNC_START_RECV, FUNC_START_SEND: begin
                    mode   = (f == FUNC_START_RECV) ? LINK_RECEIVE : LINK_TRANSMIT;
                    cmd    = d;
                    offset = 0;
                    ph     = PH_START;
                    status = ST_IDLE;
                    crc    = CRC_INIT;
                    if (f == FUNC_START_SEND && it.send_length != 0)
                        flen = (it.send_length > BUF_DEPTH) ? BUF_DEPTH : it.send_length;
                    go = 1'b1;
                end
                FUNC_WRITE_BUF: begin
                    store[it.entry_index] = d;
                    known[it.entry_index] = 1'b1;
                end
                FUNC_ENTER_SYNC: begin
                    mode = LINK_SYNC;
                end
                FUNC_READ_BUF: begin
                    r.read_byte = store[it.entry_index];
                end
                default: ;
            endcase
            r.tx_byte         = cmd;
            r.tx_restart      = go;
            r.link_status     = status;
            r.status_notify   = sn;
            r.progress_notify = pn;
            r.byte_count      = 10'(offset);
            if (sn) status_events[status]++;
            results_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [9:0] exp_v, logic [9:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] raw);
            result_t act;
            result_t exp_r;
            act = raw;
            if (results_due.size() == 0) begin
                $error("result %h with no transaction outstanding", raw);
                errors++;
                return;
            end
            exp_r = results_due.pop_front();
            checked++;
            compare_field("tx_byte", 10'(exp_r.tx_byte), 10'(act.tx_byte));
            compare_field("tx_restart", 10'(exp_r.tx_restart), 10'(act.tx_restart));
            compare_field("link_status", 10'(exp_r.link_status), 10'(act.link_status));
            compare_field("status_notify", 10'(exp_r.status_notify), 10'(act.status_notify));
            compare_field("progress_notify", 10'(exp_r.progress_notify),
                          10'(act.progress_notify));
            compare_field("byte_count", exp_r.byte_count, act.byte_count);
            compare_field("read_byte", 10'(exp_r.read_byte), 10'(act.read_byte));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    link_scoreboard sb = new();

    int src_idle_pct  = 34;
    int sink_idle_pct = 70;
    int hold_req      = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int n_items       = 0;

    serial_link_transfer_engine #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_serial_link_transfer_engine: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [8:0] rand_index();
        return 9'($urandom_range(0, BUF_DEPTH - 1));
    endfunction

    function automatic logic [9:0] rand_len();
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic logic [7:0] other_than(logic [7:0] x);
        logic [7:0] b;
        b = rand_byte();
        return (b == x) ? ~x : b;
    endfunction

    task automatic issue(input logic [2:0] f, input logic [7:0] d, input logic [8:0] idx,
                         input logic [9:0] slen);
        item_t it;
        it.data_byte   = d;
        it.entry_index = idx;
        it.send_length = slen;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {5'd0, it};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_accepted(f, it);
        n_items++;
    endtask

    task automatic serial_in(input logic [7:0] d);
        issue(FUNC_SERIAL, d, rand_index(), rand_len());
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic buffer_poke();
        logic [8:0] idx;
        idx = rand_index();
        if (sb.known[idx] && $urandom_range(0, 1))
            issue(FUNC_READ_BUF, rand_byte(), idx, rand_len());
        else
            issue(FUNC_WRITE_BUF, rand_byte(), idx, rand_len());
    endtask

    // fill every entry the send will fetch
    task automatic prepare_send(input int unsigned len);
        for (int i = 0; i < len; i++) begin
            if (!sb.known[i]) issue(FUNC_WRITE_BUF, rand_byte(), 9'(i), rand_len());
        end
    endtask

    task automatic sync_exchange();
        issue(FUNC_ENTER_SYNC, rand_byte(), rand_index(), rand_len());
        serial_in(rand_byte());
        repeat ($urandom_range(0, 2)) serial_in(other_than(BYTE_SYNC_ACK));
        if ($urandom_range(0, 99) < 85) serial_in(BYTE_SYNC_ACK);
        repeat ($urandom_range(0, 1)) serial_in(rand_byte());
    endtask

    task automatic receive_frame(input int len, input bit full_run);
        int         sel;
        logic [7:0] b;
        issue(FUNC_START_RECV, rand_byte(), rand_index(), rand_len());
        repeat ($urandom_range(0, 2)) serial_in(other_than(BYTE_FRAME_START));
        serial_in(BYTE_FRAME_START);
        for (int i = 0; i < len; i++) begin
            sel = $urandom_range(0, 99);
            if (!full_run && sel < 2) return;
            if (sel < 5) buffer_poke();
            b = rand_byte();
            if (sel < 20) begin
                case ($urandom_range(0, 3))
                    0: b = BYTE_FRAME_START;
                    1: b = BYTE_FRAME_END;
                    2: b = BYTE_ESCAPE;
                    default: b = 8'h00;
                endcase
            end
            if (b == BYTE_ESCAPE || b == BYTE_FRAME_END || sel >= 95) serial_in(BYTE_ESCAPE);
            serial_in(b);
        end
        serial_in(BYTE_FRAME_END);
        serial_in(($urandom_range(0, 99) < 75) ? sb.crc : rand_byte());
        repeat ($urandom_range(0, 2)) serial_in(rand_byte());
        if ($urandom_range(0, 99) < 30) sync_exchange();
    endtask

    task automatic send_frame(input logic [9:0] slen, input bit full_run);
        int unsigned eff;
        int          guard;
        if (slen == 0) eff = sb.flen;
        else eff = (slen > BUF_DEPTH) ? BUF_DEPTH : slen;
        prepare_send(eff);
        issue(FUNC_START_SEND, rand_byte(), rand_index(), slen);
        guard = 0;
        while (sb.ph != PH_ESCAPE && guard < 1500) begin
            if (!full_run && $urandom_range(0, 99) < 2) return;
            if (!full_run && $urandom_range(0, 99) < 3) buffer_poke();
            if ($urandom_range(0, 99) < 8) serial_in(other_than(sb.cmd));
            else serial_in(sb.cmd);
            guard++;
        end
        repeat ($urandom_range(0, 2)) serial_in(other_than(BYTE_TRAILER_ACK));
        serial_in(BYTE_TRAILER_ACK);
        repeat ($urandom_range(0, 3))
            serial_in(($urandom_range(0, 99) < 80) ? BYTE_TRAILER_ACK : rand_byte());
        if ($urandom_range(0, 99) < 40) sync_exchange();
    endtask

    task automatic noise_items();
        logic [2:0]  f;
        logic [9:0]  slen;
        repeat ($urandom_range(1, 4)) begin
            f = 3'($urandom_range(0, 7));
            if (f == FUNC_START_SEND) begin
                slen = 10'($urandom_range(1, 8));
                prepare_send(slen);
                issue(f, rand_byte(), rand_index(), slen);
            end else if (f == FUNC_READ_BUF) begin
                buffer_poke();
            end else begin
                issue(f, rand_byte(), rand_index(), rand_len());
            end
        end
    endtask

    initial begin
        int   stage;
        int   start_count;
        int   sel;
        bit   big_rx_done;
        bit   big_tx_done;
        logic [9:0] slen;
        stage       = 0;
        big_rx_done = 1'b0;
        big_tx_done = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        serial_in(8'h00);
        serial_in(8'hFF);
        issue(FUNC_UNUSED_A, 8'hFF, 9'h1FF, 10'h3FF);
        issue(FUNC_UNUSED_B, 8'h00, 9'h000, 10'h000);
        issue(FUNC_WRITE_BUF, 8'hFF, 9'h1FF, 10'h000);
        issue(FUNC_WRITE_BUF, 8'hA5, 9'h000, 10'h3FF);
        issue(FUNC_READ_BUF, 8'h00, 9'h1FF, 10'h000);
        issue(FUNC_READ_BUF, 8'hFF, 9'h000, 10'h000);
        issue(FUNC_ENTER_SYNC, 8'h00, 9'h000, 10'h000);
        serial_in(BYTE_SYNC_ACK);
        issue(FUNC_START_RECV, 8'h00, 9'h000, 10'h000);
        serial_in(8'h00);
        serial_in(BYTE_FRAME_START);
        serial_in(BYTE_ESCAPE);
        serial_in(BYTE_FRAME_END);
        serial_in(8'h1F);
        serial_in(BYTE_FRAME_END);
        serial_in(sb.crc);
        serial_in(8'h00);
        issue(FUNC_ENTER_SYNC, 8'hFF, 9'h1FF, 10'h3FF);
        serial_in(8'h55);
        serial_in(BYTE_SYNC_ACK);
        issue(FUNC_START_SEND, 8'h7F, 9'h000, 10'h000);
        serial_in(8'h7F);
        serial_in(BYTE_TRAILER_ACK);

        start_count = n_items;
        while (n_items < start_count + RANDOM_ITEMS) begin
            if (stage == 0 && n_items >= start_count + 500) begin
                wait_drained();
                src_idle_pct  = 70;
                sink_idle_pct = 34;
                stage         = 1;
            end else if (stage == 1 && n_items >= start_count + 1000) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                hold_req      = 150;
                stage         = 2;
            end
            sel = $urandom_range(0, 99);
            if (!big_rx_done && n_items >= start_count + 250) begin
                receive_frame(520, 1'b1);
                big_rx_done = 1'b1;
            end else if (big_rx_done && !big_tx_done && n_items >= start_count + 850) begin
                send_frame(10'($urandom_range(513, 1023)), 1'b1);
                big_tx_done = 1'b1;
            end else if (sel < 40) begin
                receive_frame(($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                           : $urandom_range(13, 40), 1'b0);
            end else if (sel < 75) begin
                slen = 10'($urandom_range(1, 16));
                if ($urandom_range(0, 99) < 15 && sb.flen <= 40) slen = 10'd0;
                send_frame(slen, 1'b0);
            end else if (sel < 85) begin
                sync_exchange();
            end else begin
                noise_items();
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        $display("summary: %0d transactions driven, %0d results checked, %0d mismatches",
                 n_items, sb.checked, sb.errors);
        $display("summary: status events busy %0d complete %0d failed %0d wait-sync %0d sync %0d",
                 sb.status_events[ST_BUSY], sb.status_events[ST_COMPLETE],
                 sb.status_events[ST_FAILED], sb.status_events[ST_WAIT_SYNC],
                 sb.status_events[ST_SYNC_DONE]);
        if (sb.errors == 0) begin
            $display("tb_serial_link_transfer_engine: PASS");
        end else begin
            $display("tb_serial_link_transfer_engine: FAIL");
        end
        $finish;
    end

endmodule
